FILE: hw/rtl/triangle_walk_point_locate_unit_macros.svh
// assertion macros for the triangle walk point locate unit
// no dependencies
`ifndef TRIANGLE_WALK_POINT_LOCATE_UNIT_MACROS_SVH
`define TRIANGLE_WALK_POINT_LOCATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TW_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TW_ASSERT(label, clk, rst_n, prop, msg)
`define TW_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/twpl_pkg.sv
// package for the triangle walk point locate unit
// types, constants and function codes shared by twpl_cross and the top level
package twpl_pkg;
    localparam int unsigned MaxPoints   = 1024;
    localparam int unsigned MaxAdjSlots = 8192;
    localparam int unsigned CoordBits   = 24;
    localparam logic [15:0] StepsReset  = 16'd4096;

    typedef enum logic [1:0] {
        FUNC_POINT = 2'd0,
        FUNC_LEND  = 2'd1,
        FUNC_ADJ   = 2'd2,
        FUNC_LOC   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WAIT,
        ST_MUL,
        ST_CMP,
        ST_LIST_RD,
        ST_LIST_WAIT,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_NEXT_WAIT,
        ST_FIRST_WAIT,
        ST_MOVE,
        ST_DONE
    } t_state;
endpackage

FILE: hw/rtl/twpl_cross.sv
// registered cross product right-of test for one edge
// depends on twpl_pkg
module twpl_cross #(
    parameter int unsigned COORD_BITS = twpl_pkg::CoordBits
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_rx,
    input  logic signed [COORD_BITS-1:0] i_ry,
    output logic                  o_right
);
    import twpl_pkg::*;
    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;

    logic signed [PW-1:0] r_lhs, r_rhs;
    logic signed [DW-1:0] dqx, dqy, drx, dry;

    assign dqx = DW'(i_qx) - DW'(i_px);
    assign dry = DW'(i_ry) - DW'(i_py);
    assign dqy = DW'(i_qy) - DW'(i_py);
    assign drx = DW'(i_rx) - DW'(i_px);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lhs <= dqx * dry;
            r_rhs <= dqy * drx;
        end
    end

    assign o_right = r_lhs > r_rhs;
endmodule

FILE: hw/rtl/triangle_walk_point_locate_unit.sv
// triangle walk point locate unit: top level
// Usage: start with i_func loads stores (point, list end, adjacency) or runs a locate.
// An item transfers at a rising edge with start high and busy low.
// Writes give no result. A locate gives one result on o_vertex_a/b/c, o_outside,
// o_step_limit_hit for one cycle with o_valid high.
// Steps of a locate: per tested edge two coordinate memory reads, one multiply
// stage and one compare; per move the list end reads of the far vertex and its
// predecessor (only the far vertex for vertex 0), a read of each scanned adjacency
// slot, one follow read and the move. A walk ends in the done state and the
// result shows in the cycle after it.
// One item at a time; the rate is set by the length of the walk.
// Reset clears control state and sets max_walk_steps to 4096; the stores are
// undefined until written. The receiver cannot stall: each result is shown once.
// i_cfg_we writes max_walk_steps; user to do so while the unit is idle (not checked).
`include "triangle_walk_point_locate_unit_macros.svh"
module triangle_walk_point_locate_unit #(
    parameter int unsigned COORD_BITS    = twpl_pkg::CoordBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_func,
    input  logic [12:0] i_index,
    input  logic signed [23:0] i_coord_x,
    input  logic signed [23:0] i_coord_y,
    input  logic signed [13:0] i_list_value,
    input  logic [9:0]  i_start_i,
    input  logic [9:0]  i_start_j,
    input  logic [9:0]  i_start_k,
    output logic        o_valid,
    output logic [9:0]  o_vertex_a,
    output logic [9:0]  o_vertex_b,
    output logic [9:0]  o_vertex_c,
    output logic        o_outside,
    output logic        o_step_limit_hit
);
    import twpl_pkg::*;
    localparam int unsigned MAX_POINTS    = MaxPoints;
    localparam int unsigned MAX_ADJ_SLOTS = MaxAdjSlots;
    localparam int unsigned VW = $clog2(MAX_POINTS);
    localparam int unsigned SW = $clog2(MAX_ADJ_SLOTS);
    localparam int unsigned CW = COORD_BITS;

    logic signed [CW-1:0] mem_x [MAX_POINTS];
    logic signed [CW-1:0] mem_y [MAX_POINTS];
    logic [12:0]          mem_end [MAX_POINTS];
    logic [10:0]          mem_adj [MAX_ADJ_SLOTS];

    t_state r_state, n_state;
    logic [15:0] r_max, r_cnt, n_cnt;
    logic [9:0]  r_i, r_j, r_k, n_i, n_j, n_k;
    logic [1:0]  r_edge, n_edge;
    logic signed [CW-1:0] r_qx, r_qy, n_qx, n_qy;
    logic signed [CW-1:0] r_px, r_py, n_px, n_py;
    logic [12:0] r_start, n_start, r_end, n_end;
    logic [13:0] r_slot, n_slot;
    logic        r_phase, n_phase;
    logic        r_valid, n_valid, r_out, n_out, r_lim, n_lim;
    logic [9:0]  r_nb, n_nb;

    // memory port control
    logic [VW-1:0] pt_addr;
    logic          end_rd;
    logic [VW-1:0] end_addr;
    logic [SW-1:0] adj_addr;
    logic signed [CW-1:0] rd_x, rd_y;
    logic [12:0] rd_end;
    logic [10:0] rd_adj;
    logic        wr_acc;
    logic        cross_load, cross_right;
    logic [9:0]  ea, eb, far_v, near_v;
    logic [13:0] last14;

    assign wr_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (wr_acc && t_func'(i_func) == FUNC_POINT && 32'(i_index) < MAX_POINTS) begin
            mem_x[i_index[VW-1:0]] <= CW'(i_coord_x);
            mem_y[i_index[VW-1:0]] <= CW'(i_coord_y);
        end
        rd_x <= mem_x[pt_addr];
        rd_y <= mem_y[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_acc && t_func'(i_func) == FUNC_LEND && 32'(i_index) < MAX_POINTS)
            mem_end[i_index[VW-1:0]] <= i_list_value[12:0];
        if (end_rd)
            rd_end <= mem_end[end_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_acc && t_func'(i_func) == FUNC_ADJ && 32'(i_index) < MAX_ADJ_SLOTS)
            mem_adj[i_index[SW-1:0]] <= i_list_value[13] ? 11'h7FF : {1'b0, i_list_value[9:0]};
        rd_adj <= mem_adj[adj_addr];
    end

    twpl_cross #(.COORD_BITS(CW)) u_cross (
        .i_clk(i_clk), .i_load(cross_load),
        .i_qx(r_qx), .i_qy(r_qy), .i_px(r_px), .i_py(r_py),
        .i_rx(rd_x), .i_ry(rd_y), .o_right(cross_right)
    );

    // edge endpoints: 0 i->j, 1 j->k, 2 k->i
    always_comb begin
        case (r_edge)
            2'd0:    begin ea = r_i; eb = r_j; end
            2'd1:    begin ea = r_j; eb = r_k; end
            default: begin ea = r_k; eb = r_i; end
        endcase
        far_v  = eb;
        near_v = ea;
    end

    assign last14 = {1'b0, r_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max   <= StepsReset;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_edge  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we)
                r_max <= i_cfg_wdata;
            r_cnt <= n_cnt; r_i <= n_i; r_j <= n_j; r_k <= n_k; r_edge <= n_edge;
        end
        r_qx <= n_qx; r_qy <= n_qy; r_px <= n_px; r_py <= n_py;
        r_start <= n_start; r_end <= n_end; r_slot <= n_slot; r_phase <= n_phase;
        r_out <= n_out; r_lim <= n_lim; r_nb <= n_nb;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_k = r_k;
        n_edge = r_edge; n_qx = r_qx; n_qy = r_qy; n_px = r_px; n_py = r_py;
        n_start = r_start; n_end = r_end; n_slot = r_slot; n_phase = r_phase;
        n_out = r_out; n_lim = r_lim; n_nb = r_nb; n_valid = 1'b0;
        pt_addr = ea[VW-1:0]; end_rd = 1'b0; end_addr = far_v[VW-1:0];
        adj_addr = r_slot[SW-1:0]; cross_load = 1'b0;
        busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (wr_acc && t_func'(i_func) == FUNC_LOC) begin
                    n_qx = CW'(i_coord_x); n_qy = CW'(i_coord_y);
                    n_i = i_start_i; n_j = i_start_j; n_k = i_start_k;
                    n_cnt = '0; n_edge = 2'd0; n_out = 1'b0; n_lim = 1'b0;
                    n_state = ST_EDGE_RD;
                end
            end
            ST_EDGE_RD: begin
                pt_addr = ea[VW-1:0];
                n_state = ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT: begin
                n_px = rd_x; n_py = rd_y;
                pt_addr = eb[VW-1:0];
                n_state = ST_MUL;
            end
            ST_MUL: begin
                cross_load = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (cross_right) begin
                    n_state = ST_LIST_RD;
                end else if (r_edge == 2'd2) begin
                    n_state = ST_DONE;
                end else begin
                    n_edge = r_edge + 2'd1;
                    n_state = ST_EDGE_RD;
                end
            end
            ST_LIST_RD: begin
                // list end of far vertex, then that of its predecessor
                end_rd = 1'b1; end_addr = far_v[VW-1:0];
                n_phase = 1'b0;
                n_state = ST_LIST_WAIT;
            end
            ST_LIST_WAIT: begin
                if (!r_phase) begin
                    n_end = rd_end;
                    if (far_v[VW-1:0] == '0) begin
                        n_start = '0; n_slot = 14'd0; n_state = ST_SCAN_RD;
                    end else begin
                        end_rd = 1'b1; end_addr = far_v[VW-1:0] - 1'b1;
                        n_phase = 1'b1;
                    end
                end else begin
                    n_start = rd_end + 13'd1;
                    n_slot = 14'(rd_end) + 14'd1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_slot > last14) begin
                    adj_addr = r_start[SW-1:0];
                    n_state = ST_FIRST_WAIT;
                end else begin
                    adj_addr = r_slot[SW-1:0];
                    n_state = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                if (rd_adj == {1'b0, near_v}) begin
                    if (r_slot < last14) begin
                        adj_addr = SW'(r_slot + 14'd1);
                        n_state = ST_NEXT_WAIT;
                    end else begin
                        adj_addr = r_start[SW-1:0];
                        n_state = ST_FIRST_WAIT;
                    end
                end else begin
                    n_slot = r_slot + 14'd1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_NEXT_WAIT, ST_FIRST_WAIT: begin
                n_nb = rd_adj[9:0];
                if (rd_adj[10]) begin
                    n_out = 1'b1; n_state = ST_DONE;
                end else if (r_cnt >= r_max) begin
                    n_lim = 1'b1; n_state = ST_DONE;
                end else begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                n_i = far_v; n_j = near_v; n_k = r_nb;
                n_cnt = r_cnt + 16'd1; n_edge = 2'd0;
                n_state = ST_EDGE_RD;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_valid;
    assign o_vertex_a = r_i;
    assign o_vertex_b = r_j;
    assign o_vertex_c = r_k;
    assign o_outside = r_out;
    assign o_step_limit_hit = r_lim;

    `TW_ASSERT(a_flags_excl, i_clk, i_rst_n, o_valid |-> !(o_outside && o_step_limit_hit), "both flags")
    `TW_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "result without locate")
    `TW_ASSERT(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid, "result repeated")
    `TW_ASSERT(a_limit_cnt, i_clk, i_rst_n, (o_valid && o_step_limit_hit) |-> (r_cnt >= r_max), "limit early")
endmodule
